>>> sv/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared constants for the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_WIDTH = 16;

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    // port field widths
    localparam int IN_IDX_W   = 4;
    localparam int IN_SIZE_W  = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // fit policy codes
    localparam logic [1:0] POL_FIRST  = 2'd0;
    localparam logic [1:0] POL_BEST   = 2'd1;
    localparam logic [1:0] POL_WORST  = 2'd2;
    localparam logic [1:0] POL_UNUSED = 2'd3;

    // register indexes (paddr[2])
    localparam logic REG_FIT_POLICY  = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    // input action codes
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

endpackage

>>> sv/fpba_ram.sv
// ----------------------------------------------------------------------------
// fpba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/fit_policy_block_allocator_top.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top
// Keeps the remaining size of each block in a RAM and serves allocation
// requests by first, best or worst fit.
// ----------------------------------------------------------------------------
// Load: one transaction per cycle while the block is idle, no result.
// Request: one RAM read per block in use, issued through the single RAM read
//   port while scanning; the result is then registered in the done state once the
//   result slot is free, and the block returns to idle, where the next item is taken.
// One request in flight at a time; a new item is taken while a result waits.
// Reset: fit_policy = first fit, block_count = 16, all blocks unloaded.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_top
    import fpba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [3:0] block_index, [19:4] size_value
    input  logic                  i_s_tuser,   // [0] action
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [3:0] chosen_block
    output logic                  o_m_tuser,   // [0] granted
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} t_state;

    t_state                r_state;
    logic [1:0]            r_fit_policy;
    logic [4:0]            r_block_count;
    logic [NUM_BLOCKS-1:0] r_loaded;
    logic [SIZE_WIDTH-1:0] r_req_size;
    logic [CNT_W-1:0]      r_issue;
    logic                  r_pend;
    logic [IDX_W-1:0]      r_pend_idx;
    logic                  r_found;
    logic [IDX_W-1:0]      r_pick;
    logic [SIZE_WIDTH-1:0] r_best;
    logic                  r_out_valid;
    logic                  r_out_granted;
    logic [OUT_IDX_W-1:0]  r_out_block;

    logic                  in_acc;
    logic                  cfg_wr;
    logic                  load_ok;
    logic [IDX_W-1:0]      load_idx;
    logic [SIZE_WIDTH-1:0] in_size;
    logic [CNT_W-1:0]      limit;
    logic                  rd_en;
    logic                  fits;
    logic                  take;
    logic                  out_free;
    logic                  finish;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [SIZE_WIDTH-1:0] ram_wdata;
    logic [SIZE_WIDTH-1:0] ram_rdata;

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;

    assign load_ok  = (32'(i_s_tdata[IN_IDX_W-1:0]) < NUM_BLOCKS);
    assign load_idx = IDX_W'(i_s_tdata[IN_IDX_W-1:0]);
    assign in_size  = SIZE_WIDTH'(i_s_tdata[IN_IDX_W +: IN_SIZE_W]);

    assign limit = (32'(r_block_count) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                     : CNT_W'(r_block_count);
    assign rd_en = (r_state == ST_SCAN) && (r_issue < limit);

    // candidate evaluation on the data read last cycle
    assign fits = r_pend && r_loaded[r_pend_idx] && (ram_rdata >= r_req_size);
    always_comb begin
        take = 1'b0;
        if (fits) begin
            if (!r_found) begin
                take = 1'b1;
            end else if (r_fit_policy == POL_BEST) begin
                take = (ram_rdata < r_best);
            end else if (r_fit_policy == POL_WORST) begin
                take = (ram_rdata > r_best);
            end
        end
    end

    assign out_free = !r_out_valid || i_m_tready;
    assign finish   = (r_state == ST_DONE) && out_free;

    always_comb begin
        if (r_state == ST_DONE) begin
            ram_we    = finish && r_found;
            ram_waddr = r_pick;
            ram_wdata = r_best - r_req_size;
        end else begin
            ram_we    = in_acc && (i_s_tuser == ACT_LOAD) && load_ok;
            ram_waddr = load_idx;
            ram_wdata = in_size;
        end
    end

    fpba_ram #(
        .WIDTH (SIZE_WIDTH),
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (r_issue[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_fit_policy  <= POL_FIRST;
            r_block_count <= 5'd16;
            r_loaded      <= '0;
            r_issue       <= '0;
            r_pend        <= 1'b0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_FIT_POLICY) begin
                    r_fit_policy <= pwdata[1:0];
                end else begin
                    r_block_count <= pwdata[4:0];
                end
            end
            if (r_out_valid && i_m_tready && !finish) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_s_tuser == ACT_REQUEST) begin
                            r_req_size <= in_size;
                            r_issue    <= '0;
                            r_pend     <= 1'b0;
                            r_found    <= 1'b0;
                            r_state    <= ST_SCAN;
                        end else if (load_ok) begin
                            r_loaded[load_idx] <= 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    r_pend     <= rd_en;
                    r_pend_idx <= r_issue[IDX_W-1:0];
                    if (rd_en) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (take) begin
                        r_found <= 1'b1;
                        r_pick  <= r_pend_idx;
                        r_best  <= ram_rdata;
                    end
                    if (!rd_en && !r_pend) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_granted <= r_found;
                        r_out_block   <= r_found ? OUT_IDX_W'(r_pick) : '0;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_granted;
    assign o_m_tdata  = {{(OUT_DATA_W - OUT_IDX_W){1'b0}}, r_out_block};

    always_comb begin
        if (paddr[2] == REG_FIT_POLICY) begin
            prdata = {{(CFG_DATA_W - 2){1'b0}}, r_fit_policy};
        end else begin
            prdata = {{(CFG_DATA_W - 5){1'b0}}, r_block_count};
        end
    end

    // no RAM write may land while a scan is reading
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !ram_we)
        else $error("RAM write during scan");

    // the current pick is always a loaded block
    a_pick_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_found) |-> r_loaded[r_pick])
        else $error("picked block not loaded");

    // every pending read lies inside the blocks in use
    a_pend_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_pend) |-> (CNT_W'(r_pend_idx) < limit))
        else $error("scan read beyond block count");

    // a refused request reports block zero
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("refused result with nonzero block");

endmodule

>>> bench/fit_policy_block_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top_tb
// Drives block size loads and allocation requests into the allocator under
// first, best and worst fit and a range of block counts, and predicts every
// grant and chosen block from a cycle-free copy of the block table.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_top_tb;
    import fpba_pkg::*;

    localparam int  CLK_PERIOD  = 20;
    localparam int  SETTLE_CYC  = NUM_BLOCKS + 8;
    localparam int  NUM_PHASES  = 12;
    localparam int  PHASE_ITEMS = 165;
    localparam real TIMEOUT_NS  = 10_000_000.0;

    typedef struct packed {
        logic                 granted;
        logic [OUT_IDX_W-1:0] block;
    } t_alloc;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the block table and holds the pending allocations
    // ------------------------------------------------------------------------
    class alloc_scoreboard;
        logic [1:0]            policy;
        logic [4:0]            count;
        logic [SIZE_WIDTH-1:0] remaining [NUM_BLOCKS];
        bit                    loaded [NUM_BLOCKS];
        t_alloc                pending_allocs [$];
        int                    errors;
        int                    items;
        int                    requests;
        int                    grants;

        function new();
            policy   = POL_FIRST;
            count    = 5'd16;
            errors   = 0;
            items    = 0;
            requests = 0;
            grants   = 0;
            foreach (loaded[j]) begin
                loaded[j]    = 1'b0;
                remaining[j] = '0;
            end
        endfunction

        function void set_register(logic reg_sel, logic [CFG_DATA_W-1:0] value);
            if (reg_sel == REG_FIT_POLICY) begin
                policy = value[1:0];
            end else begin
                count = value[4:0];
            end
        endfunction

        // apply one request to the table and return the outcome
        function t_alloc charge_request(logic [SIZE_WIDTH-1:0] size);
            t_alloc res;
            int     lim;
            int     pick;
            bit     found;
            lim   = (count > NUM_BLOCKS) ? NUM_BLOCKS : int'(count);
            pick  = 0;
            found = 1'b0;
            for (int j = 0; j < lim; j++) begin
                if (loaded[j] && remaining[j] >= size) begin
                    if (!found) begin
                        found = 1'b1;
                        pick  = j;
                        // first fit and the unused code stop at the first hit
                        if (policy != POL_BEST && policy != POL_WORST) break;
                    end else if (policy == POL_BEST && remaining[j] < remaining[pick]) begin
                        pick = j;
                    end else if (policy == POL_WORST && remaining[j] > remaining[pick]) begin
                        pick = j;
                    end
                end
            end
            res.granted = found;
            res.block   = '0;
            if (found) begin
                remaining[pick] = remaining[pick] - size;
                res.block       = pick[OUT_IDX_W-1:0];
            end
            return res;
        endfunction

        function void note_item(logic act, logic [IN_IDX_W-1:0] idx,
                                logic [IN_SIZE_W-1:0] size);
            t_alloc res;
            items++;
            if (act == ACT_LOAD) begin
                remaining[idx] = size[SIZE_WIDTH-1:0];
                loaded[idx]    = 1'b1;
            end else begin
                res = charge_request(size[SIZE_WIDTH-1:0]);
                requests++;
                if (res.granted) grants++;
                pending_allocs.push_back(res);
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic granted, logic [OUT_IDX_W-1:0] block);
            t_alloc want;
            if (pending_allocs.size() == 0) begin
                report_mismatch($sformatf("unexpected result granted=%0b block=%0d",
                                          granted, block));
            end else begin
                want = pending_allocs.pop_front();
                if (granted !== want.granted)
                    report_mismatch($sformatf("granted %0b, predicted %0b",
                                              granted, want.granted));
                if (block !== want.block)
                    report_mismatch($sformatf("chosen_block %0d, predicted %0d",
                                              block, want.block));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = ACT_LOAD;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    alloc_scoreboard sb;
    int              idle_pct = 30;
    int              settings_run = 0;

    fit_policy_block_allocator_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", sb.pending_allocs.size());
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random backpressure, check every transaction
    initial begin
        forever begin
            @(negedge i_clk);
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[OUT_IDX_W-1:0]);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers (entered and left at a falling edge)
    // ------------------------------------------------------------------------
    task send_item(logic act, logic [IN_IDX_W-1:0] idx, logic [IN_SIZE_W-1:0] size);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(IN_DATA_W - IN_SIZE_W - IN_IDX_W){1'b0}}, size, idx};
        do @(posedge i_clk); while (!s_tready);
        sb.note_item(act, idx, size);
        @(negedge i_clk);
    endtask

    task apb_write(logic reg_sel, logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(reg_sel, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for the pipeline to empty; a trailing load gives no result to wait on
    task drain;
        s_tvalid <= 1'b0;
        while (sb.pending_allocs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task set_mode(logic [1:0] policy, logic [4:0] count);
        drain();
        apb_write(REG_FIT_POLICY, {{(CFG_DATA_W-2){1'b0}}, policy});
        apb_write(REG_BLOCK_COUNT, {{(CFG_DATA_W-5){1'b0}}, count});
        settings_run++;
    endtask

    task run_random(int n);
        logic                 act;
        logic [IN_IDX_W-1:0]  idx;
        logic [IN_SIZE_W-1:0] size;
        for (int k = 0; k < n; k++) begin
            act = ($urandom_range(0, 99) < 35) ? ACT_LOAD : ACT_REQUEST;
            idx = IN_IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
            if (act == ACT_LOAD) begin
                case ($urandom_range(0, 3))
                    0:       size = IN_SIZE_W'($urandom_range(0, 16'hFFFF));
                    1:       size = IN_SIZE_W'($urandom_range(0, 7));      // forces ties
                    default: size = IN_SIZE_W'($urandom_range(0, 1023));
                endcase
            end else begin
                case ($urandom_range(0, 9))
                    0:       size = '0;
                    1:       size = '1;
                    2:       size = IN_SIZE_W'($urandom_range(0, 16'hFFFF));
                    3:       size = IN_SIZE_W'($urandom_range(0, 7));
                    default: size = IN_SIZE_W'($urandom_range(0, 255));
                endcase
            end
            send_item(act, idx, size);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    logic [1:0] phase_policy [NUM_PHASES] = '{POL_FIRST, POL_BEST, POL_WORST, POL_UNUSED,
                                              POL_BEST, POL_WORST, POL_FIRST, POL_WORST,
                                              POL_BEST, POL_FIRST, POL_WORST, POL_BEST};
    logic [4:0] phase_count  [NUM_PHASES] = '{5'd16, 5'd16, 5'd16, 5'd8,
                                              5'd1, 5'd0, 5'd31, 5'd5,
                                              5'd12, 5'd16, 5'd31, 5'd16};

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: first fit over all blocks, nothing loaded yet
        send_item(ACT_REQUEST, 4'd0, 16'd0);
        send_item(ACT_LOAD, 4'd0, 16'hFFFF);
        send_item(ACT_LOAD, 4'd15, 16'd0);
        send_item(ACT_LOAD, 4'd3, 16'd100);
        send_item(ACT_LOAD, 4'd5, 16'd40);
        send_item(ACT_LOAD, 4'd9, 16'd100);
        send_item(ACT_LOAD, 4'd12, 16'd40);
        send_item(ACT_REQUEST, 4'd7, 16'd0);        // zero size charges nothing
        send_item(ACT_REQUEST, 4'd0, 16'hFFFF);
        send_item(ACT_REQUEST, 4'd0, 16'd50);
        send_item(ACT_REQUEST, 4'd0, 16'hFFFF);     // nothing large enough left

        set_mode(POL_BEST, 5'd16);
        send_item(ACT_REQUEST, 4'd0, 16'd40);       // tie between two 40s
        send_item(ACT_REQUEST, 4'd0, 16'd1);
        set_mode(POL_WORST, 5'd16);
        send_item(ACT_REQUEST, 4'd0, 16'd10);
        send_item(ACT_REQUEST, 4'd0, 16'd0);
        set_mode(POL_UNUSED, 5'd16);                 // unused code acts as first fit
        send_item(ACT_REQUEST, 4'd0, 16'd5);
        set_mode(POL_FIRST, 5'd0);
        send_item(ACT_REQUEST, 4'd0, 16'd0);
        set_mode(POL_FIRST, 5'd31);
        send_item(ACT_REQUEST, 4'd0, 16'd1);
        set_mode(POL_WORST, 5'd4);
        send_item(ACT_LOAD, 4'd10, 16'hFFFF);       // stored but outside the count
        send_item(ACT_REQUEST, 4'd0, 16'd1000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_mode(phase_policy[p], phase_count[p]);
            idle_pct = (p == 9) ? 0 : 30;           // one back-to-back stretch
            run_random(PHASE_ITEMS);
        end
        idle_pct = 30;

        drain();
        $display("Ran %0d items: %0d requests, %0d granted, %0d register settings",
                 sb.items, sb.requests, sb.grants, settings_run);
        $display("Policies first/best/worst/unused, block counts 0 through 31");
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
